@@ src/scpc_pkg.sv @@
// ----------------------------------------------------------------------------
// scpc_pkg - shared types and constants for the set crossing pair check
// Beat layouts, command codes, defaults and the control word of a trait cell.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int MAX_ROWS_DEF   = 32;
  localparam int MAX_TRAITS_DEF = 32;
  localparam int TRAIT_W        = 5;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TRAIT_W-1:0] trait_id;
  } in_item_t;

  typedef struct packed {
    logic               not_tree;
    logic [TRAIT_W-1:0] first_trait;
    logic [TRAIT_W-1:0] second_trait;
    logic               overflowed;
  } out_item_t;

  // Control word broadcast to every trait cell.
  typedef struct packed {
    logic               add;
    logic               shift;
    logic [TRAIT_W-1:0] trait_id;
  } cell_ctl_t;

endpackage

@@ src/scpc_cell.sv @@
// ----------------------------------------------------------------------------
// scpc_cell - one trait column of the membership chain
// Holds the set membership of one trait and compares it against the probe.
// ----------------------------------------------------------------------------
module scpc_cell #(
  parameter int MAX_ROWS = scpc_pkg::MAX_ROWS_DEF,
  parameter int INDEX    = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scpc_pkg::cell_ctl_t  ctl,
  input  logic [MAX_ROWS-1:0]  row_mask,
  input  logic [MAX_ROWS-1:0]  next_col,
  input  logic                 next_seen,
  input  logic [MAX_ROWS-1:0]  probe_col,
  output logic [MAX_ROWS-1:0]  col,
  output logic                 seen,
  output logic                 crosses
);
  import scpc_pkg::*;

  logic hit_me;

  assign hit_me = ctl.trait_id == TRAIT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      seen <= 1'b0;
    end else if (ctl.shift) begin
      col  <= next_col;
      seen <= next_seen;
    end else if (ctl.add && hit_me) begin
      col  <= col | row_mask;
      seen <= 1'b1;
    end
  end

  // Shared row, a row with only this trait, and a row with only the probe.
  assign crosses = seen && (|(col & probe_col)) && (|(col & ~probe_col))
                   && (|(probe_col & ~col));

endmodule

@@ src/set_crossing_pair_check.sv @@
// ----------------------------------------------------------------------------
// set_crossing_pair_check - crossing pair check over a loaded set family
// Loads sets of trait numbers and reports the first pair of traits that
// cross, i.e. whether the family fails to form a tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_item) carries one command per beat:
//   add a trait to the open set, close the open set, or end the data.
//   Add and close beats give no result; unused codes are dropped. An end
//   beat starts a walk along the chain of trait cells, one step for each of
//   the min(MAX_TRAITS, 32) trait cells, then loads the output register.
//   in_ready is low for both. The walk is the shift of the cell chain, one
//   trait column per cycle.
//   Output channel (out_valid / out_ready / out_item) carries one result per
//   end beat. The result sits in an output register; loading resumes while it
//   waits. If the receiver still stalls a previous result when the walk ends,
//   the block holds until that register frees.
//   Reset clears every cell, the row counter and the overflow flag. The walk
//   shifts zeros into the chain, so the store is empty again once it ends.
// ----------------------------------------------------------------------------
module set_crossing_pair_check #(
  parameter int MAX_ROWS   = scpc_pkg::MAX_ROWS_DEF,
  parameter int MAX_TRAITS = scpc_pkg::MAX_TRAITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output scpc_pkg::out_item_t out_item
);
  import scpc_pkg::*;

  // Trait ids are five bits wide, so no more than 32 cells are ever used.
  localparam int NCELL = (MAX_TRAITS < 32) ? MAX_TRAITS : 32;
  localparam int IDXW  = $clog2(NCELL);
  localparam int RCW   = $clog2(MAX_ROWS + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state;
  logic [RCW-1:0]      row_count;
  logic                overflow_flag;
  logic [IDXW-1:0]     walk_idx;
  logic                hit;
  logic [IDXW-1:0]     hit_i;
  logic [IDXW-1:0]     hit_j;

  logic                in_fire;
  logic                rows_full;
  logic                trait_in_range;
  logic                out_free;
  logic [MAX_ROWS-1:0] row_mask;
  cell_ctl_t           ctl;

  logic [MAX_ROWS-1:0] cell_col [NCELL];
  logic [NCELL-1:0]    cell_seen;
  logic [NCELL-1:0]    cell_cross;
  logic [IDXW-1:0]     sel_k;
  logic                any_cross;

  assign in_ready       = state == ST_LOAD;
  assign in_fire        = in_valid && in_ready;
  assign rows_full      = row_count == RCW'(MAX_ROWS);
  assign trait_in_range = {1'b0, in_item.trait_id} < 6'(NCELL);
  assign out_free       = !out_valid || out_ready;
  assign row_mask       = MAX_ROWS'(1) << row_count;

  // Broadcast control: add only while rows remain, shift on every walk cycle.
  assign ctl.add      = in_fire && in_item.cmd == CMD_ADD && !rows_full;
  assign ctl.shift    = state == ST_WALK;
  assign ctl.trait_id = in_item.trait_id;

  // Chain of trait cells. Cell 0 holds the probe trait of the current walk
  // step; every cell hands its column one place down each walk cycle and the
  // tail takes zeros, which empties the store by the end of the walk.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [MAX_ROWS-1:0] nxt_col;
    logic                nxt_seen;
    if (k == NCELL - 1) begin : g_tail
      assign nxt_col  = '0;
      assign nxt_seen = 1'b0;
    end else begin : g_link
      assign nxt_col  = cell_col[k+1];
      assign nxt_seen = cell_seen[k+1];
    end
    scpc_cell #(
      .MAX_ROWS (MAX_ROWS),
      .INDEX    (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .row_mask  (row_mask),
      .next_col  (nxt_col),
      .next_seen (nxt_seen),
      .probe_col (cell_col[0]),
      .col       (cell_col[k]),
      .seen      (cell_seen[k]),
      .crosses   (cell_cross[k])
    );
  end

  // Pick the nearest crossing cell; it is the smallest partner trait.
  // Cell 0 compares against itself and never crosses.
  always_comb begin
    sel_k     = '0;
    any_cross = 1'b0;
    for (int k = NCELL - 1; k >= 0; k--) begin
      if (cell_cross[k]) begin
        sel_k     = IDXW'(k);
        any_cross = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      row_count     <= '0;
      overflow_flag <= 1'b0;
      walk_idx      <= '0;
      hit           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is published now.
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            unique case (in_item.cmd)
              CMD_ADD: begin
                // Drop adds once all rows are full; flag those with an in-range trait.
                if (trait_in_range && rows_full) begin
                  overflow_flag <= 1'b1;
                end
              end
              CMD_CLOSE: begin
                if (rows_full) begin
                  overflow_flag <= 1'b1;
                end else begin
                  row_count <= row_count + RCW'(1);
                end
              end
              CMD_END: begin
                walk_idx <= '0;
                hit      <= 1'b0;
                state    <= ST_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          // Keep only the first crossing pair in walk order.
          if (!hit && cell_seen[0] && any_cross) begin
            hit   <= 1'b1;
            hit_i <= walk_idx;
            hit_j <= walk_idx + sel_k;
          end
          if (walk_idx == IDXW'(NCELL - 1)) begin
            state <= ST_FINISH;
          end else begin
            walk_idx <= walk_idx + IDXW'(1);
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free, then publish and rearm.
          if (out_free) begin
            out_valid     <= 1'b1;
            row_count     <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_item.not_tree     <= hit;
      out_item.first_trait  <= hit ? TRAIT_W'(hit_i) : '0;
      out_item.second_trait <= hit ? TRAIT_W'(hit_j) : '0;
      out_item.overflowed   <= overflow_flag;
    end
  end

endmodule
